FILE: src/prfp_pkg.sv
// Shared types and constants for the palette RGB444 packer.
// No dependencies.
`default_nettype none

package prfp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned NIBBLE_W  = 4;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned COLOUR_W  = 12;
  localparam int unsigned PAIR_W    = 2 * COLOUR_W;
  localparam int unsigned BYTES_PER_PAIR = PAIR_W / BYTE_W;
  localparam logic [1:0]  LAST_BYTE = 2'(BYTES_PER_PAIR - 1);

  typedef enum logic {
    OP_PAL_WRITE = 1'b0,
    OP_PIXEL     = 1'b1
  } op_e;

  typedef struct packed {
    logic [COLOUR_W-1:0] colour_a;
    logic [COLOUR_W-1:0] colour_b;
    logic                row_end;
  } ser_load_t;

endpackage

`default_nettype wire

FILE: src/palette_rgb444_flush_packer.sv
// A pixel request is held in the lookup stage (registered palette reads), then
// the byte output register sends its pair as three bytes while the next request
// waits in the lookup stage; palette writes are taken one per cycle unless a
// held pixel stalls the input. Reset: control clears, four_bit_mode returns to 1;
// the palette store is not cleared and must be loaded before use.
`default_nettype none

module palette_rgb444_flush_packer #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,     // four_bit_mode
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,    // entry_index[7:0], entry_colour[23:8],
                                            // first_byte[31:24], second_byte[39:32]
  input  wire logic        s_axis_tlast,    // row_end
  input  wire logic        s_axis_tuser,    // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,    // out_byte
  output logic             m_axis_tlast,    // pair_last
  output logic             m_axis_tuser     // row_last
);

  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned BW = prfp_pkg::BYTE_W;
  localparam logic [BW:0] DEPTH_V = (BW+1)'(PALETTE_DEPTH);

  logic                           mode_q;
  logic [BW-1:0]                  entry_index;
  logic [prfp_pkg::WORD_W-1:0]    entry_colour;
  logic [BW-1:0]                  first_byte, second_byte;
  logic [BW-1:0]                  idx_a, idx_b;
  logic                           accept, pix_accept, wr_accept;
  logic                           s1_valid_q, s1_valid_d;
  logic                           s1_in_a_q, s1_in_b_q, s1_rend_q;
  logic                           s1_move;
  logic                           ser_free;
  logic [prfp_pkg::WORD_W-1:0]    rdata_a, rdata_b;
  logic [prfp_pkg::WORD_W-1:0]    col_a, col_b;
  prfp_pkg::ser_load_t            ser_load;

  assign entry_index  = s_axis_tdata[7:0];
  assign entry_colour = s_axis_tdata[23:8];
  assign first_byte   = s_axis_tdata[31:24];
  assign second_byte  = s_axis_tdata[39:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (mode_q) begin
      idx_a = {prfp_pkg::NIBBLE_W'(0), first_byte[BW-1 -: prfp_pkg::NIBBLE_W]};
      idx_b = {prfp_pkg::NIBBLE_W'(0), first_byte[prfp_pkg::NIBBLE_W-1:0]};
    end else begin
      idx_a = first_byte;
      idx_b = second_byte;
    end
  end

  assign s1_move       = s1_valid_q && ser_free;
  assign s_axis_tready = !s1_valid_q || s1_move;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pix_accept    = accept && (prfp_pkg::op_e'(s_axis_tuser) == prfp_pkg::OP_PIXEL);
  assign wr_accept     = accept && (prfp_pkg::op_e'(s_axis_tuser) == prfp_pkg::OP_PAL_WRITE)
                         && ({1'b0, entry_index} < DEPTH_V);

  prfp_pal_mem #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (AW)
  ) u_pal_mem (
    .clk_i     (clk_i),
    .we_i      (wr_accept),
    .waddr_i   (entry_index[AW-1:0]),
    .wdata_i   (entry_colour),
    .re_i      (pix_accept),
    .raddr_a_i (idx_a[AW-1:0]),
    .raddr_b_i (idx_b[AW-1:0]),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    if (pix_accept) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_accept) begin
      s1_in_a_q <= ({1'b0, idx_a} < DEPTH_V);
      s1_in_b_q <= ({1'b0, idx_b} < DEPTH_V);
      s1_rend_q <= s_axis_tlast;
    end
  end

  // out-of-range indices read as zero; the top nibble of b ORs into the middle byte
  always_comb begin
    col_a = s1_in_a_q ? rdata_a : '0;
    col_b = s1_in_b_q ? rdata_b : '0;
    ser_load.colour_a = {col_a[prfp_pkg::COLOUR_W-1:prfp_pkg::NIBBLE_W],
                         col_a[prfp_pkg::NIBBLE_W-1:0] |
                         col_b[prfp_pkg::WORD_W-1:prfp_pkg::COLOUR_W]};
    ser_load.colour_b = col_b[prfp_pkg::COLOUR_W-1:0];
    ser_load.row_end  = s1_rend_q;
  end

  prfp_byte_ser u_byte_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (s1_move),
    .load_data_i   (ser_load),
    .free_o        (ser_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !ser_free |=> s1_valid_q)
    else $error("lookup stage dropped a request while output busy");

  a_s1_loads_ser: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> m_axis_tvalid && !m_axis_tlast)
    else $error("serializer not started on first byte after load");

  a_row_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("row_last flagged off the pair's final byte");

  a_no_write_on_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_accept && pix_accept))
    else $error("palette write and pixel read in the same request");

endmodule

`default_nettype wire

FILE: src/prfp_pal_mem.sv
// Palette store: one write port, two registered read ports.
// Depends on prfp_pkg.
`default_nettype none

module prfp_pal_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [AW-1:0]               waddr_i,
  input  wire logic [prfp_pkg::WORD_W-1:0] wdata_i,
  input  wire logic                        re_i,
  input  wire logic [AW-1:0]               raddr_a_i,
  input  wire logic [AW-1:0]               raddr_b_i,
  output logic      [prfp_pkg::WORD_W-1:0] rdata_a_o,
  output logic      [prfp_pkg::WORD_W-1:0] rdata_b_o
);

  logic [prfp_pkg::WORD_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/prfp_byte_ser.sv
// Output register: splits a looked-up colour pair into three bytes.
// Depends on prfp_pkg.
`default_nettype none

module prfp_byte_ser (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        load_i,
  input  wire prfp_pkg::ser_load_t         load_data_i,
  output logic                             free_o,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [prfp_pkg::BYTE_W-1:0]      m_axis_tdata,
  output logic                             m_axis_tlast,
  output logic                             m_axis_tuser
);

  logic                          valid_q, valid_d;
  logic [1:0]                    cnt_q, cnt_d;
  logic [prfp_pkg::PAIR_W-1:0]   word_q, word_d;
  logic                          rend_q, rend_d;
  logic                          take;
  logic                          last;

  assign take   = valid_q && m_axis_tready;
  assign last   = (cnt_q == prfp_pkg::LAST_BYTE);
  assign free_o = !valid_q || (take && last);

  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    word_d  = word_q;
    rend_d  = rend_q;
    if (take) begin
      cnt_d  = cnt_q + 2'd1;
      word_d = {word_q[prfp_pkg::PAIR_W-prfp_pkg::BYTE_W-1:0], prfp_pkg::BYTE_W'(0)};
      if (last) begin
        valid_d = 1'b0;
      end
    end
    if (load_i) begin
      valid_d = 1'b1;
      cnt_d   = 2'd0;
      word_d  = {load_data_i.colour_a, load_data_i.colour_b};
      rend_d  = load_data_i.row_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    rend_q <= rend_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = word_q[prfp_pkg::PAIR_W-1 -: prfp_pkg::BYTE_W];
  assign m_axis_tlast  = last;
  assign m_axis_tuser  = last && rend_q;

endmodule

`default_nettype wire
